>>> hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> hdl/c20_pkg.sv
package c20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_A         = 3'd0;
    localparam logic [2:0] REG_KEY_B         = 3'd1;
    localparam logic [2:0] REG_KEY_C         = 3'd2;
    localparam logic [2:0] REG_KEY_D         = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW     = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH    = 3'd5;
    localparam logic [2:0] REG_COUNTER_START = 3'd6;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } quad_t;

    // Word address of operand k (0..3 = a,b,c,d) of quarter round q of a double round.
    function automatic logic [3:0] qr_addr(input logic [2:0] q, input logic [1:0] k);
        logic [1:0] base;
        logic [1:0] lane;
        base = q[1:0];
        if (!q[2])
            lane = base;
        else
            lane = base + k;
        qr_addr = {k, lane};
    endfunction

endpackage

>>> hdl/c20_ifs.sv
interface c20_in_if;
    import c20_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       last_in_message;
    modport source (output valid, data_in, last_in_message, input ready);
    modport sink (input valid, data_in, last_in_message, output ready);
endinterface

interface c20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_out;
    modport source (output valid, data_out, last_out, input ready);
    modport sink (input valid, data_out, last_out, output ready);
endinterface

interface c20_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/c20_qhalf.sv
// One half of a quarter round: two add, xor and rotate steps.
module c20_qhalf
    import c20_pkg::*;
(
    input  quad_t din,
    input  logic  second,
    output quad_t dout
);
    logic [31:0] a1, d1, d2, c1, b1, b2;

    always_comb
    begin
        a1 = din.a + din.b;
        d1 = din.d ^ a1;
        d2 = second ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
        c1 = din.c + d2;
        b1 = din.b ^ c1;
        b2 = second ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
        dout.a = a1;
        dout.b = b2;
        dout.c = c1;
        dout.d = d2;
    end
endmodule

>>> hdl/chacha20_stream_xor.sv
// ChaCha20 byte stream XOR (IETF layout, 96-bit nonce). One byte goes in and one
// comes out per item. A byte that finds a keystream block ready goes from S_IDLE
// through S_FETCH to S_BYTE, where its result is registered once the result
// register is free; a new byte is taken only back in S_IDLE, so the block takes
// no new byte before it is through with the last. A byte that needs a new block
// first waits for its generation: the initial words are loaded, then each of the
// ten double rounds runs eight quarter rounds (read a and b, read c and d, two
// halves, then four write-backs through the single write port of the working-state
// memory), then the feed-forward. Configuration is taken at once in any cycle.
`include "assert_macros.svh"

module chacha20_stream_xor
    import c20_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    c20_in_if.sink   din,
    c20_out_if.source dout,
    c20_cfg_if.sink  cfg
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RD_AB, S_RD_CD, S_QR1, S_QR2, S_WB,
        S_FF_RD, S_FF_WR, S_FETCH, S_BYTE
    } state_t;

    state_t state_reg;
    logic [63:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg, counter_start_reg, block_cnt_reg;
    logic [5:0]  pos_reg;
    logic        block_ready_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic [3:0]  idx_reg;
    logic [2:0]  q_reg;
    logic [1:0]  wk_reg;
    logic [RND_W-1:0] rnd_reg;
    quad_t       quad_reg;

    logic [31:0] rs_mem [16];
    logic [31:0] ks_mem [16];
    logic [31:0] rs_rd_a, rs_rd_b, ks_rd;
    logic [3:0]  rs_ra, rs_rb;
    logic        rs_we, ks_we;
    logic [3:0]  rs_wa;
    logic [31:0] rs_wd, ks_wd, init_w, wb_word;
    quad_t       half_in, half_out;
    logic        in_acc;
    logic        byte_fire;

    assign din.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign in_acc = din.valid && din.ready;
    assign dout.valid = out_valid_reg;
    assign dout.data_out = out_data_reg;
    assign dout.last_out = out_last_reg;

    // The result register must be free or emptied this cycle.
    assign byte_fire = (state_reg == S_BYTE) && (!out_valid_reg || dout.ready);

    always_comb
    begin
        case (idx_reg)
            4'd0: init_w = SIGMA0;
            4'd1: init_w = SIGMA1;
            4'd2: init_w = SIGMA2;
            4'd3: init_w = SIGMA3;
            4'd4: init_w = key_a_reg[31:0];
            4'd5: init_w = key_a_reg[63:32];
            4'd6: init_w = key_b_reg[31:0];
            4'd7: init_w = key_b_reg[63:32];
            4'd8: init_w = key_c_reg[31:0];
            4'd9: init_w = key_c_reg[63:32];
            4'd10: init_w = key_d_reg[31:0];
            4'd11: init_w = key_d_reg[63:32];
            4'd12: init_w = counter_start_reg + block_cnt_reg;
            4'd13: init_w = nonce_low_reg[31:0];
            4'd14: init_w = nonce_low_reg[63:32];
            default: init_w = nonce_high_reg;
        endcase
    end

    always_comb
    begin
        case (wk_reg)
            2'd0: wb_word = quad_reg.a;
            2'd1: wb_word = quad_reg.b;
            2'd2: wb_word = quad_reg.c;
            default: wb_word = quad_reg.d;
        endcase
    end

    always_comb
    begin
        rs_ra = idx_reg;
        rs_rb = qr_addr(q_reg, 2'd1);
        case (state_reg)
            S_RD_AB:
            begin
                rs_ra = qr_addr(q_reg, 2'd0);
                rs_rb = qr_addr(q_reg, 2'd1);
            end
            S_RD_CD:
            begin
                rs_ra = qr_addr(q_reg, 2'd2);
                rs_rb = qr_addr(q_reg, 2'd3);
            end
            default:
            begin
                rs_ra = idx_reg;
                rs_rb = qr_addr(q_reg, 2'd1);
            end
        endcase
        rs_we = (state_reg == S_INIT) || (state_reg == S_WB);
        rs_wa = (state_reg == S_WB) ? qr_addr(q_reg, wk_reg) : idx_reg;
        rs_wd = (state_reg == S_WB) ? wb_word : init_w;
        ks_we = (state_reg == S_FF_WR);
        ks_wd = rs_rd_a + init_w;
        half_in = quad_reg;
        if (state_reg == S_QR1)
        begin
            half_in.c = rs_rd_a;
            half_in.d = rs_rd_b;
        end
    end

    c20_qhalf u_qhalf (
        .din    (half_in),
        .second (state_reg == S_QR2),
        .dout   (half_out)
    );

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[rs_wa] <= rs_wd;
        rs_rd_a <= rs_mem[rs_ra];
        rs_rd_b <= rs_mem[rs_rb];
    end

    always_ff @(posedge clk)
    begin
        if (ks_we)
            ks_mem[idx_reg] <= ks_wd;
        ks_rd <= ks_mem[pos_reg[5:2]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg <= '0;
            key_b_reg <= '0;
            key_c_reg <= '0;
            key_d_reg <= '0;
            nonce_low_reg <= '0;
            nonce_high_reg <= '0;
            counter_start_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_KEY_A: key_a_reg <= cfg.data;
                REG_KEY_B: key_b_reg <= cfg.data;
                REG_KEY_C: key_c_reg <= cfg.data;
                REG_KEY_D: key_d_reg <= cfg.data;
                REG_NONCE_LOW: nonce_low_reg <= cfg.data;
                REG_NONCE_HIGH: nonce_high_reg <= cfg.data[31:0];
                REG_COUNTER_START: counter_start_reg <= cfg.data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg <= '0;
            block_cnt_reg <= '0;
            block_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_last_reg <= 1'b0;
            data_reg <= '0;
            last_reg <= 1'b0;
            quad_reg <= '0;
            idx_reg <= '0;
            q_reg <= '0;
            wk_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            if (byte_fire)
                out_valid_reg <= 1'b1;
            else if (dout.valid && dout.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        data_reg <= din.data_in;
                        last_reg <= din.last_in_message;
                        idx_reg <= '0;
                        state_reg <= block_ready_reg ? S_FETCH : S_INIT;
                    end
                end
                S_INIT:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == 4'd15)
                    begin
                        q_reg <= '0;
                        rnd_reg <= '0;
                        state_reg <= S_RD_AB;
                    end
                end
                S_RD_AB: state_reg <= S_RD_CD;
                S_RD_CD:
                begin
                    quad_reg.a <= rs_rd_a;
                    quad_reg.b <= rs_rd_b;
                    state_reg <= S_QR1;
                end
                S_QR1:
                begin
                    quad_reg <= half_out;
                    state_reg <= S_QR2;
                end
                S_QR2:
                begin
                    quad_reg <= half_out;
                    wk_reg <= '0;
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    wk_reg <= wk_reg + 2'd1;
                    if (wk_reg == 2'd3)
                    begin
                        q_reg <= q_reg + 3'd1;
                        state_reg <= S_RD_AB;
                        if (q_reg == 3'd7)
                        begin
                            rnd_reg <= rnd_reg + RND_W'(1);
                            if (rnd_reg == RND_W'(DOUBLE_ROUNDS - 1))
                            begin
                                idx_reg <= '0;
                                state_reg <= S_FF_RD;
                            end
                        end
                    end
                end
                S_FF_RD: state_reg <= S_FF_WR;
                S_FF_WR:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == 4'd15)
                    begin
                        block_ready_reg <= 1'b1;
                        state_reg <= S_FETCH;
                    end
                    else
                        state_reg <= S_FF_RD;
                end
                S_FETCH: state_reg <= S_BYTE;
                S_BYTE:
                begin
                    if (byte_fire)
                    begin
                        out_data_reg <= data_reg ^ 8'(ks_rd >> {pos_reg[1:0], 3'b000});
                        out_last_reg <= last_reg;
                        state_reg <= S_IDLE;
                        if (last_reg)
                        begin
                            pos_reg <= '0;
                            block_cnt_reg <= '0;
                            block_ready_reg <= 1'b0;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 6'd1;
                            if (pos_reg == 6'd63)
                            begin
                                block_cnt_reg <= block_cnt_reg + 32'd1;
                                block_ready_reg <= 1'b0;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_out_from_byte, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_BYTE))
    `ASSERT_NEVER(a_pos_without_block, clk, rst_n, (pos_reg != 6'd0) && !block_ready_reg)
    `ASSERT_NEVER(a_init_with_block, clk, rst_n, (state_reg == S_INIT) && block_ready_reg)
endmodule

>>> tb/tb_ifs_note.sv
package tb_c20_pkg;
    import c20_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;
endpackage

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import c20_pkg::*;
    import tb_c20_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;

    c20_in_if  din ();
    c20_out_if dout ();
    c20_cfg_if cfg ();

    chacha20_stream_xor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din.sink),
        .dout  (dout.source),
        .cfg   (cfg.sink)
    );

    // Cipher state held by the predictor.
    logic [63:0] key_words [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] ctr_start;
    logic [31:0] ks_block [16];
    logic [5:0]  ks_pos;
    logic [31:0] blocks_done;
    bit          ks_valid;

    byte_item_t pending_bytes [$];
    byte_item_t expected_bytes [$];

    int  mismatches;
    int  idle_cycles;

    function automatic logic [31:0] rotl32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix_quarter(ref logic [31:0] w [16], input int a, int b,
                                        input int c, int d);
        w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
    endfunction

    function automatic void build_keystream();
        logic [31:0] init_w [16];
        logic [31:0] work [16];
        init_w[0] = SIGMA0;
        init_w[1] = SIGMA1;
        init_w[2] = SIGMA2;
        init_w[3] = SIGMA3;
        for (int k = 0; k < 4; k++)
        begin
            init_w[4 + 2 * k] = key_words[k][31:0];
            init_w[5 + 2 * k] = key_words[k][63:32];
        end
        init_w[12] = ctr_start + blocks_done;
        init_w[13] = nonce_lo[31:0];
        init_w[14] = nonce_lo[63:32];
        init_w[15] = nonce_hi;
        work = init_w;
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            mix_quarter(work, 0, 4, 8, 12);
            mix_quarter(work, 1, 5, 9, 13);
            mix_quarter(work, 2, 6, 10, 14);
            mix_quarter(work, 3, 7, 11, 15);
            mix_quarter(work, 0, 5, 10, 15);
            mix_quarter(work, 1, 6, 11, 12);
            mix_quarter(work, 2, 7, 8, 13);
            mix_quarter(work, 3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++)
            ks_block[k] = work[k] + init_w[k];
        ks_valid = 1'b1;
    endfunction

    function automatic byte_item_t encrypt_byte(byte_item_t in_item);
        byte_item_t res;
        logic [31:0] word;
        if (!ks_valid)
            build_keystream();
        word = ks_block[ks_pos[5:2]];
        res.data = in_item.data ^ word[ks_pos[1:0] * 8 +: 8];
        res.last = in_item.last;
        if (in_item.last)
        begin
            ks_pos = '0;
            blocks_done = '0;
            ks_valid = 1'b0;
        end
        else
        begin
            ks_pos = ks_pos + 6'd1;
            if (ks_pos == 6'd0)
            begin
                blocks_done = blocks_done + 32'd1;
                ks_valid = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            REG_KEY_A:         key_words[0] = value;
            REG_KEY_B:         key_words[1] = value;
            REG_KEY_C:         key_words[2] = value;
            REG_KEY_D:         key_words[3] = value;
            REG_NONCE_LOW:     nonce_lo = value;
            REG_NONCE_HIGH:    nonce_hi = value[31:0];
            REG_COUNTER_START: ctr_start = value[31:0];
            default:           ;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Whether the item on the input channel was taken at the last rising edge.
    bit in_acc_q;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_acc_q <= 1'b0;
        else
            in_acc_q <= din.valid && din.ready;
    end

    // Byte driver: takes items from the pending queue, with random gaps.
    int drive_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din.valid <= 1'b0;
            din.data_in <= '0;
            din.last_in_message <= 1'b0;
            drive_gap <= 0;
        end
        else
        begin
            if (din.valid && !in_acc_q)
                ;
            else if (drive_gap > 0)
            begin
                drive_gap <= drive_gap - 1;
                din.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                din.valid <= 1'b1;
                din.data_in <= pending_bytes[0].data;
                din.last_in_message <= pending_bytes[0].last;
                void'(pending_bytes.pop_front());
                drive_gap <= pick_gap();
            end
            else
                din.valid <= 1'b0;
        end
    end

    // Result sink stall pattern.
    int stall_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            dout.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            dout.ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Monitor: predicts on input acceptance, tracks configuration writes, checks on output acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din.valid && din.ready)
                expected_bytes.push_back(encrypt_byte('{din.data_in, din.last_in_message}));
            if (cfg.valid && cfg.ready)
                apply_reg(cfg.index, cfg.data);
            if (dout.valid && dout.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output byte %02h last %0b",
                                 dout.data_out, dout.last_out);
                end
                else
                begin
                    byte_item_t exp_b;
                    exp_b = expected_bytes.pop_front();
                    if (exp_b.data !== dout.data_out || exp_b.last !== dout.last_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte mismatch: expected %02h/%0b got %02h/%0b",
                                     exp_b.data, exp_b.last, dout.data_out, dout.last_out);
                    end
                end
            end
            if ((din.valid && din.ready) || (dout.valid && dout.ready)
                || (cfg.valid && cfg.ready) || expected_bytes.size() == 0
                   && pending_bytes.size() == 0 && !din.valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain_bytes();
        while (pending_bytes.size() > 0 || din.valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_settings(int mode);
        logic [63:0] v [7];
        for (int k = 0; k < 7; k++)
        begin
            case (mode)
                0: v[k] = '0;
                1: v[k] = '1;
                default: v[k] = rand64();
            endcase
        end
        // Counter near its top so that a long message can cross the wrap.
        if (mode >= 2 && $urandom_range(0, 1))
            v[6] = 64'hFFFF_FFFF - $urandom_range(0, 2);
        write_reg(REG_KEY_A, v[0]);
        write_reg(REG_KEY_B, v[1]);
        write_reg(REG_KEY_C, v[2]);
        write_reg(REG_KEY_D, v[3]);
        write_reg(REG_NONCE_LOW, v[4]);
        write_reg(REG_NONCE_HIGH, v[5]);
        write_reg(REG_COUNTER_START, v[6]);
    endtask

    task automatic queue_message(int len);
        byte_item_t it;
        for (int k = 0; k < len; k++)
        begin
            it.data = $urandom_range(0, 255);
            it.last = (k == len - 1);
            pending_bytes.push_back(it);
        end
    endtask

    int sent;
    initial
    begin
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        mismatches = 0;
        idle_cycles = 0;
        key_words = '{default: '0};
        nonce_lo = '0;
        nonce_hi = '0;
        ctr_start = '0;
        ks_pos = '0;
        blocks_done = '0;
        ks_valid = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, extreme bytes, a single-byte message, counter at its top value.
        pending_bytes.push_back('{8'h00, 1'b0});
        pending_bytes.push_back('{8'hFF, 1'b1});
        pending_bytes.push_back('{8'hA5, 1'b1});
        drain_bytes();
        load_settings(1);
        pending_bytes.push_back('{8'h5A, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b1});
        drain_bytes();
        load_settings(2);
        write_reg(REG_COUNTER_START, 64'hFFFF_FFFF);
        queue_message(20);
        drain_bytes();

        sent = 25;
        while (sent < 1700)
        begin
            int len;
            load_settings($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2);
            for (int m = 0; m < 3; m++)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 200)
                                                  : $urandom_range(1, 70);
                queue_message(len);
                sent += len;
            end
            // A write in the middle of a message takes effect at the next block.
            drain_bytes();
            if ($urandom_range(0, 2) == 0)
            begin
                queue_message(40);
                pending_bytes[pending_bytes.size() - 1].last = 1'b0;
                drain_bytes();
                write_reg(REG_COUNTER_START, rand64());
                queue_message(60);
                sent += 100;
                drain_bytes();
            end
        end
        drain_bytes();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/c20_pkg.sv
hdl/c20_ifs.sv
hdl/c20_qhalf.sv
hdl/chacha20_stream_xor.sv
tb/tb_ifs_note.sv
tb/tb_top.sv
